@@ src/kxd_pkg.sv @@
// Shared types and constants of the keyed XOR stream decryptor.
`default_nettype none

package kxd_pkg;

	// CRC-32, reflected form of 0x04C11DB7
	localparam logic [31:0] KXD_CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] KXD_CRC_INIT = 32'hFFFFFFFF;
	localparam logic [15:0] KXD_MWC_A = 16'h9069;
	localparam logic [15:0] KXD_MWC_B = 16'h4650;
	localparam logic [8:0] KXD_SKIP_BASE = 9'd10;

	// seed text: head, optional minus, decimal digits, tail
	localparam logic [31:0] KXD_HEAD = 32'h5F4D4A44; // "_MJD"
	localparam logic [31:0] KXD_TAIL = 32'h2352574B; // "#RWK"
	localparam logic [7:0] KXD_CHAR_MINUS = 8'h2D;
	localparam logic [7:0] KXD_CHAR_ZERO = 8'h30;
	localparam int KXD_DIGITS = 10;

	// entries between front and back; a power of two
	localparam int KXD_QDEPTH = 4;

	typedef enum logic [2:0] {
		PH_KEY,
		PH_SEED,
		PH_LOAD,
		PH_SKIP,
		PH_DEC
	} phase_t;

	typedef enum logic [2:0] {
		SD_IDLE,
		SD_BCD,
		SD_HEAD,
		SD_SIGN,
		SD_DIGIT,
		SD_TAIL,
		SD_DONE
	} seed_state_t;

	typedef enum logic [1:0] {
		KXD_PASS,
		KXD_DEC,
		KXD_SEEDS
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [1:0]  nbytes_m1;
		logic        last;
		logic [31:0] word;   // bytes little-endian, or seed one
		logic [31:0] aux;    // seed two
	} entry_t;

	typedef struct packed {
		logic        start;
		logic        abort;
		logic [31:0] key;
	} seed_ctl_t;

	typedef struct packed {
		logic        done;
		logic [31:0] seed;
	} seed_sts_t;

endpackage

`default_nettype wire

@@ src/kxd_if.sv @@
// Byte stream channel interfaces of the decryptor.
`default_nettype none

interface kxd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;
	modport source(output valid, output in_byte, output in_last, input ready);
	modport sink(input valid, input in_byte, input in_last, output ready);
endinterface

interface kxd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;
	modport source(output valid, output out_byte, output out_last, input ready);
	modport sink(input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

@@ src/kxd_seed.sv @@
// Seed-two derivation: key to decimal (shift-add-3), then CRC-32 of the UTF-16LE text.
`default_nettype none

module kxd_seed (
	input  logic                 clk,
	input  logic                 arst_n,
	input  kxd_pkg::seed_ctl_t   ctl,
	output kxd_pkg::seed_sts_t   sts
);

	kxd_pkg::seed_state_t state_q, state_d;
	logic [31:0] mag_q, mag_d;
	logic        neg_q, neg_d;
	logic [3:0]  bcd_q [kxd_pkg::KXD_DIGITS];
	logic [3:0]  bcd_d [kxd_pkg::KXD_DIGITS];
	logic [3:0]  adj [kxd_pkg::KXD_DIGITS];
	logic [4:0]  bit_q, bit_d;
	logic [3:0]  idx_q, idx_d;
	logic        half_q, half_d;
	logic        started_q, started_d;
	logic [31:0] crc_q, crc_d;
	logic [7:0]  ch;
	logic        feed;
	logic [3:0]  digit;

	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'b0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ kxd_pkg::KXD_CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= kxd_pkg::SD_IDLE;
			mag_q     <= '0;
			neg_q     <= 1'b0;
			bit_q     <= '0;
			idx_q     <= '0;
			half_q    <= 1'b0;
			started_q <= 1'b0;
			crc_q     <= kxd_pkg::KXD_CRC_INIT;
			for (int i = 0; i < kxd_pkg::KXD_DIGITS; i++) bcd_q[i] <= '0;
		end else begin
			state_q   <= state_d;
			mag_q     <= mag_d;
			neg_q     <= neg_d;
			bit_q     <= bit_d;
			idx_q     <= idx_d;
			half_q    <= half_d;
			started_q <= started_d;
			crc_q     <= crc_d;
			for (int i = 0; i < kxd_pkg::KXD_DIGITS; i++) bcd_q[i] <= bcd_d[i];
		end
	end

	assign digit = bcd_q[idx_q];

	always_comb begin
		state_d   = state_q;
		mag_d     = mag_q;
		neg_d     = neg_q;
		bit_d     = bit_q;
		idx_d     = idx_q;
		half_d    = half_q;
		started_d = started_q;
		ch        = '0;
		feed      = 1'b0;
		for (int i = 0; i < kxd_pkg::KXD_DIGITS; i++) begin
			bcd_d[i] = bcd_q[i];
			adj[i]   = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
		end

		unique case (state_q)
			kxd_pkg::SD_IDLE, kxd_pkg::SD_DONE: begin
			end
			kxd_pkg::SD_BCD: begin
				bcd_d[0] = {adj[0][2:0], mag_q[31]};
				for (int i = 1; i < kxd_pkg::KXD_DIGITS; i++) begin
					bcd_d[i] = {adj[i][2:0], adj[i-1][3]};
				end
				mag_d = mag_q << 1;
				bit_d = bit_q + 5'd1;
				if (bit_q == 5'd31) begin
					state_d = kxd_pkg::SD_HEAD;
					idx_d   = '0;
					half_d  = 1'b0;
				end
			end
			kxd_pkg::SD_HEAD: begin
				ch     = kxd_pkg::KXD_HEAD[{~idx_q[1:0], 3'b000} +: 8];
				feed   = 1'b1;
				half_d = ~half_q;
				if (half_q) begin
					idx_d = idx_q + 4'd1;
					if (idx_q[1:0] == 2'd3) begin
						state_d   = neg_q ? kxd_pkg::SD_SIGN : kxd_pkg::SD_DIGIT;
						idx_d     = 4'(kxd_pkg::KXD_DIGITS - 1);
						started_d = 1'b0;
					end
				end
			end
			kxd_pkg::SD_SIGN: begin
				ch     = kxd_pkg::KXD_CHAR_MINUS;
				feed   = 1'b1;
				half_d = ~half_q;
				if (half_q) state_d = kxd_pkg::SD_DIGIT;
			end
			kxd_pkg::SD_DIGIT: begin
				// leading zeros are skipped, but the units digit always goes out
				if (!started_q && digit == 4'd0 && idx_q != 4'd0) begin
					idx_d = idx_q - 4'd1;
				end else begin
					started_d = 1'b1;
					ch        = kxd_pkg::KXD_CHAR_ZERO + {4'b0, digit};
					feed      = 1'b1;
					half_d    = ~half_q;
					if (half_q) begin
						if (idx_q == 4'd0) begin
							state_d = kxd_pkg::SD_TAIL;
						end else begin
							idx_d = idx_q - 4'd1;
						end
					end
				end
			end
			kxd_pkg::SD_TAIL: begin
				ch     = kxd_pkg::KXD_TAIL[{~idx_q[1:0], 3'b000} +: 8];
				feed   = 1'b1;
				half_d = ~half_q;
				if (half_q) begin
					idx_d = idx_q + 4'd1;
					if (idx_q[1:0] == 2'd3) state_d = kxd_pkg::SD_DONE;
				end
			end
			default: state_d = kxd_pkg::SD_IDLE;
		endcase

		// each character is followed by a zero byte
		crc_d = feed ? crc_byte(crc_q, half_q ? 8'h00 : ch) : crc_q;

		if (ctl.abort) begin
			state_d = kxd_pkg::SD_IDLE;
		end else if (ctl.start) begin
			state_d = kxd_pkg::SD_BCD;
			neg_d   = ctl.key[31];
			mag_d   = ctl.key[31] ? (~ctl.key + 32'd1) : ctl.key;
			bit_d   = '0;
			half_d  = 1'b0;
			crc_d   = kxd_pkg::KXD_CRC_INIT;
			for (int i = 0; i < kxd_pkg::KXD_DIGITS; i++) bcd_d[i] = '0;
		end
	end

	assign sts.done = (state_q == kxd_pkg::SD_DONE);
	assign sts.seed = crc_q;

endmodule

`default_nettype wire

@@ src/kxd_front.sv @@
// Front end: takes input beats, tracks the stream phase and builds queue entries.
`default_nettype none

module kxd_front (
	input  logic                 clk,
	input  logic                 arst_n,
	kxd_in_if.sink               rx,
	input  logic                 q_full,
	output logic                 push,
	output kxd_pkg::entry_t      entry,
	output kxd_pkg::seed_ctl_t   seed_ctl,
	input  kxd_pkg::seed_sts_t   seed_sts
);

	kxd_pkg::phase_t phase_q, phase_d;
	logic [8:0]  cnt_q, cnt_d;
	logic [1:0]  pcnt_q, pcnt_d;
	logic [31:0] key_q, key_d;
	logic [31:0] seed1_q, seed1_d;
	logic [23:0] pend_q, pend_d;
	logic        fire;
	logic [8:0]  skip_len;
	logic [31:0] tail_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= kxd_pkg::PH_KEY;
			cnt_q   <= '0;
			pcnt_q  <= '0;
		end else begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			pcnt_q  <= pcnt_d;
		end
	end

	always_ff @(posedge clk) begin
		key_q   <= key_d;
		seed1_q <= seed1_d;
		pend_q  <= pend_d;
	end

	assign rx.ready = !q_full && (phase_q != kxd_pkg::PH_LOAD);
	assign fire     = rx.valid && rx.ready;
	assign skip_len = {1'b0, seed_sts.seed[7:0]} + kxd_pkg::KXD_SKIP_BASE;

	always_comb begin
		tail_word = {8'b0, pend_q};
		tail_word[{pcnt_q, 3'b000} +: 8] = rx.in_byte;
	end

	always_comb begin
		phase_d  = phase_q;
		cnt_d    = cnt_q;
		pcnt_d   = pcnt_q;
		key_d    = key_q;
		seed1_d  = seed1_q;
		pend_d   = pend_q;
		push     = 1'b0;
		entry    = '{kind: kxd_pkg::KXD_PASS, nbytes_m1: 2'd0, last: rx.in_last,
		             word: {24'b0, rx.in_byte}, aux: '0};
		seed_ctl = '{start: 1'b0, abort: 1'b0, key: {rx.in_byte, key_q[23:0]}};

		unique case (phase_q)
			kxd_pkg::PH_KEY: begin
				if (fire) begin
					push = 1'b1;
					key_d[{cnt_q[1:0], 3'b000} +: 8] = rx.in_byte;
					cnt_d = cnt_q + 9'd1;
					if (cnt_q[1:0] == 2'd3) begin
						cnt_d   = '0;
						phase_d = kxd_pkg::PH_SEED;
						seed_ctl.start = !rx.in_last;
					end
				end
			end
			kxd_pkg::PH_SEED: begin
				if (fire) begin
					push = 1'b1;
					seed1_d[{cnt_q[1:0], 3'b000} +: 8] = rx.in_byte;
					cnt_d = cnt_q + 9'd1;
					if (cnt_q[1:0] == 2'd3) begin
						cnt_d   = '0;
						phase_d = kxd_pkg::PH_LOAD;
					end
				end
			end
			kxd_pkg::PH_LOAD: begin
				// hand both seeds to the back end once seed two is ready
				if (seed_sts.done && !q_full) begin
					push    = 1'b1;
					entry   = '{kind: kxd_pkg::KXD_SEEDS, nbytes_m1: 2'd0, last: 1'b0,
					            word: seed1_q, aux: seed_sts.seed};
					phase_d = kxd_pkg::PH_SKIP;
					cnt_d   = '0;
				end
			end
			kxd_pkg::PH_SKIP: begin
				if (fire) begin
					push  = 1'b1;
					cnt_d = cnt_q + 9'd1;
					if (cnt_q + 9'd1 >= skip_len) begin
						cnt_d   = '0;
						phase_d = kxd_pkg::PH_DEC;
					end
				end
			end
			kxd_pkg::PH_DEC: begin
				if (fire) begin
					if (pcnt_q == 2'd3) begin
						push   = 1'b1;
						entry  = '{kind: kxd_pkg::KXD_DEC, nbytes_m1: 2'd3, last: rx.in_last,
						           word: {rx.in_byte, pend_q}, aux: '0};
						pcnt_d = '0;
						pend_d = '0;
					end else if (rx.in_last) begin
						// short tail: held bytes and this one go out as they are
						push  = 1'b1;
						entry = '{kind: kxd_pkg::KXD_PASS, nbytes_m1: pcnt_q, last: 1'b1,
						          word: tail_word, aux: '0};
					end else begin
						pend_d = tail_word[23:0];
						pcnt_d = pcnt_q + 2'd1;
					end
				end
			end
			default: phase_d = kxd_pkg::PH_KEY;
		endcase

		if (fire && rx.in_last) begin
			phase_d        = kxd_pkg::PH_KEY;
			cnt_d          = '0;
			pcnt_d         = '0;
			key_d          = '0;
			seed1_d        = '0;
			pend_d         = '0;
			seed_ctl.abort = 1'b1;
		end
	end

endmodule

`default_nettype wire

@@ src/kxd_queue.sv @@
// Short FIFO of work entries between the front and back ends.
`default_nettype none

module kxd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  kxd_pkg::entry_t   wr_entry,
	output logic              full,
	input  logic              pop,
	output kxd_pkg::entry_t   rd_entry,
	output logic              valid
);

	localparam int AW = $clog2(kxd_pkg::KXD_QDEPTH);

	kxd_pkg::entry_t mem_q [kxd_pkg::KXD_QDEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wr_entry;
	end

	assign full     = (cnt_q == (AW+1)'(kxd_pkg::KXD_QDEPTH));
	assign valid    = (cnt_q != '0);
	assign rd_entry = mem_q[rd_q];

endmodule

`default_nettype wire

@@ src/kxd_back.sv @@
// Back end: steps the multiply-with-carry mask and serializes bytes out.
`default_nettype none

module kxd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  kxd_pkg::entry_t   q_entry,
	output logic              pop,
	kxd_out_if.source         tx
);

	logic [31:0] s1_q, s2_q;
	logic [31:0] buf_q;
	logic [2:0]  rem_q;
	logic        last_q;
	logic [31:0] s1_next, s2_next;
	logic [31:0] mask;
	logic        out_fire;
	logic        load_bytes;

	assign out_fire   = tx.valid && tx.ready;
	assign pop        = q_valid && (rem_q == 3'd0 || (rem_q == 3'd1 && tx.ready));
	assign load_bytes = pop && (q_entry.kind != kxd_pkg::KXD_SEEDS);

	assign s1_next = 32'(s1_q[15:0]) * 32'(kxd_pkg::KXD_MWC_A) + {16'b0, s1_q[31:16]};
	assign s2_next = 32'(s2_q[15:0]) * 32'(kxd_pkg::KXD_MWC_B) + {16'b0, s2_q[31:16]};
	// the low half of (s1 << 16) is zero, so the add is a concatenation
	assign mask    = {s1_next[15:0], s2_next[15:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (load_bytes) begin
			rem_q <= {1'b0, q_entry.nbytes_m1} + 3'd1;
		end else if (out_fire) begin
			rem_q <= rem_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_bytes) begin
			buf_q  <= (q_entry.kind == kxd_pkg::KXD_DEC) ? (q_entry.word ^ mask) : q_entry.word;
			last_q <= q_entry.last;
		end else if (out_fire) begin
			buf_q <= buf_q >> 8;
		end
		if (pop && q_entry.kind == kxd_pkg::KXD_SEEDS) begin
			s1_q <= q_entry.word;
			s2_q <= q_entry.aux;
		end else if (pop && q_entry.kind == kxd_pkg::KXD_DEC) begin
			s1_q <= s1_next;
			s2_q <= s2_next;
		end
	end

	assign tx.valid    = (rem_q != 3'd0);
	assign tx.out_byte = buf_q[7:0];
	assign tx.out_last = last_q && (rem_q == 3'd1);

endmodule

`default_nettype wire

@@ src/keyed_xor_stream_decryptor.sv @@
// Path: a byte goes through the queue, then the output buffer (its dword when decrypted).
// Throughput: one byte per cycle while the output is ready, except once per stream after
// seed one: seed two takes binary-to-decimal conversion, a pass over each skipped leading
// zero and CRC work on each text character and its zero byte; the input holds after seed
// one until seed two is ready and both seeds are handed over.
// Reset: arst_n clears phase, counters, queue and output state; the block starts at the key.
`default_nettype none

module keyed_xor_stream_decryptor (
	input  logic       clk,
	input  logic       arst_n,
	kxd_in_if.sink     rx,
	kxd_out_if.source  tx
);

	logic                push;
	logic                pop;
	logic                q_full;
	logic                q_valid;
	kxd_pkg::entry_t     wr_entry;
	kxd_pkg::entry_t     rd_entry;
	kxd_pkg::seed_ctl_t  seed_ctl;
	kxd_pkg::seed_sts_t  seed_sts;

	kxd_seed u_seed (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (seed_ctl),
		.sts    (seed_sts)
	);

	kxd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.q_full   (q_full),
		.push     (push),
		.entry    (wr_entry),
		.seed_ctl (seed_ctl),
		.seed_sts (seed_sts)
	);

	kxd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.full     (q_full),
		.pop      (pop),
		.rd_entry (rd_entry),
		.valid    (q_valid)
	);

	kxd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_entry (rd_entry),
		.pop     (pop),
		.tx      (tx)
	);

`ifndef SYNTH
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("queue written while full");

	a_seeds_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(push && wr_entry.kind == kxd_pkg::KXD_SEEDS) |-> seed_sts.done)
		else $error("seeds handed over before seed two was derived");

	a_start_clears_done: assert property (@(posedge clk) disable iff (!arst_n)
		(seed_ctl.start && !seed_ctl.abort) |=> !seed_sts.done)
		else $error("seed unit reports done right after a new start");
`endif

endmodule

`default_nettype wire
